/* rtl/dhcpenc_pkg.sv */
`timescale 1ns / 1ps
// dhcpenc_pkg: shared types, constants and checksum helpers for the
// dhcp reply ipv4/udp encapsulator; no dependencies
package dhcpenc_pkg;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_TOO_SHORT = 2'd1,
    ST_TOO_LONG  = 2'd2
  } status_t;

  // register indexes on the configuration port
  localparam logic REG_MIN_LEN = 1'b0;

  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;

  localparam int          MAX_MESSAGE_BYTES_DEF = 1500;
  localparam int          QUEUE_DEPTH_DEF       = 2;
  localparam logic [10:0] MIN_LEN_RESET         = 11'd236;
  localparam int          MIN_LEN_W             = 11;
  localparam int          LEN_OUT_W             = 11;

  // running message sum width
  localparam int SUM_W = 27;
  // width of header sums before folding
  localparam int HSUM_W = 28;

  // message byte offsets of the captured fields
  localparam int FLAG_BYTE    = 10;
  localparam int YIADDR_BYTE  = 16;
  localparam int SIADDR_BYTE  = 20;
  localparam int ADDR_END     = 24;

  // header constants
  localparam int          UDP_HDR_BYTES = 8;
  localparam int          IP_HDR_BYTES  = 20;
  localparam logic [15:0] SERVER_PORT   = 16'd67;
  localparam logic [15:0] CLIENT_PORT   = 16'd68;
  localparam logic [15:0] PROTO_UDP     = 16'd17;
  localparam logic [15:0] IP_VER_IHL    = 16'h4500;
  localparam logic [31:0] ADDR_ALL_ONES = 32'hffff_ffff;

  // end-around carry fold of a header sum down to 16 bits
  function automatic logic [15:0] fold16(input logic [HSUM_W-1:0] s);
    logic [16:0] t;
    logic [16:0] u;
    t = {1'b0, s[15:0]} + 17'(s[HSUM_W-1:16]);
    u = {1'b0, t[15:0]} + 17'(t[16]);
    return u[15:0];
  endfunction

endpackage

/* rtl/dhcpenc_fifo.sv */
`timescale 1ns / 1ps
// dhcpenc_fifo: small flop-based queue between front and back
// no package dependencies; depth must be a power of two, at least 2
module dhcpenc_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             full,
  output logic             not_empty
);

  localparam int AW = $clog2(DEPTH);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [AW:0]      count_r, count_nxt;

  assign full      = (count_r == (AW+1)'(DEPTH));
  assign not_empty = (count_r != '0);
  assign pop_data  = mem_r[rd_ptr_r];

  // pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

/* rtl/dhcpenc_front.sv */
`timescale 1ns / 1ps
// dhcpenc_front: per-byte running sum, byte count and field capture;
// pushes one message summary per last byte; uses dhcpenc_pkg
module dhcpenc_front import dhcpenc_pkg::*; #(
  parameter  int MAX_MESSAGE_BYTES = MAX_MESSAGE_BYTES_DEF,
  localparam int CNT_W   = $clog2(MAX_MESSAGE_BYTES + 1),
  localparam int ENTRY_W = 2 + 32 + 32 + CNT_W + SUM_W + 8
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [7:0]           in_msg_byte,
  input  logic                 in_last,
  input  logic [MIN_LEN_W-1:0] min_len,
  input  logic                 q_full,
  output logic                 q_push,
  output logic [ENTRY_W-1:0]   q_data
);

  localparam int CMP_W = (CNT_W > MIN_LEN_W) ? CNT_W : MIN_LEN_W;

  logic [CNT_W-1:0] count_r, count_nxt;
  logic [SUM_W-1:0] sum_r, sum_nxt;
  logic [7:0]       pend_r, pend_nxt;
  logic             bcast_r, bcast_nxt;
  logic [31:0]      yi_r, yi_nxt;
  logic [31:0]      si_r, si_nxt;
  logic             ovf_r, ovf_nxt;

  logic             accept;
  status_t          status;
  logic [31:0]      dst;
  logic [7:0]       pad;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;
  assign q_push   = accept && in_last;

  // byte update: capture fields, pair bytes into words, count; flag overflow at the maximum length
  always_comb begin
    count_nxt = count_r;
    sum_nxt   = sum_r;
    pend_nxt  = pend_r;
    bcast_nxt = bcast_r;
    yi_nxt    = yi_r;
    si_nxt    = si_r;
    ovf_nxt   = ovf_r;
    if (count_r == CNT_W'(MAX_MESSAGE_BYTES)) begin
      ovf_nxt = 1'b1;
    end else begin
      if (count_r == CNT_W'(FLAG_BYTE)) begin
        bcast_nxt = in_msg_byte[7];
      end else if (count_r >= CNT_W'(YIADDR_BYTE) && count_r < CNT_W'(SIADDR_BYTE)) begin
        yi_nxt = {yi_r[23:0], in_msg_byte};
      end else if (count_r >= CNT_W'(SIADDR_BYTE) && count_r < CNT_W'(ADDR_END)) begin
        si_nxt = {si_r[23:0], in_msg_byte};
      end
      if (!count_r[0]) begin
        pend_nxt = in_msg_byte;
      end else begin
        sum_nxt = sum_r + SUM_W'({pend_r, in_msg_byte});
      end
      count_nxt = count_r + 1'b1;
    end
  end

  // message summary for the back end
  always_comb begin
    if (ovf_nxt) begin
      status = ST_TOO_LONG;
    end else if (CMP_W'(count_nxt) < CMP_W'(min_len)) begin
      status = ST_TOO_SHORT;
    end else begin
      status = ST_OK;
    end
    dst    = bcast_nxt ? ADDR_ALL_ONES : yi_nxt;
    pad    = count_nxt[0] ? pend_nxt : 8'h00;
    q_data = {status, si_nxt, dst, count_nxt, sum_nxt, pad};
  end

  // message state, cleared after each last byte
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      sum_r   <= '0;
      pend_r  <= '0;
      bcast_r <= 1'b0;
      yi_r    <= '0;
      si_r    <= '0;
      ovf_r   <= 1'b0;
    end else if (accept) begin
      if (in_last) begin
        count_r <= '0;
        sum_r   <= '0;
        pend_r  <= '0;
        bcast_r <= 1'b0;
        yi_r    <= '0;
        si_r    <= '0;
        ovf_r   <= 1'b0;
      end else begin
        count_r <= count_nxt;
        sum_r   <= sum_nxt;
        pend_r  <= pend_nxt;
        bcast_r <= bcast_nxt;
        yi_r    <= yi_nxt;
        si_r    <= si_nxt;
        ovf_r   <= ovf_nxt;
      end
    end
  end

endmodule

/* rtl/dhcpenc_back.sv */
`timescale 1ns / 1ps
// dhcpenc_back: three-stage header builder (partial sums, header sums,
// fold and output register); uses dhcpenc_pkg
module dhcpenc_back import dhcpenc_pkg::*; #(
  parameter  int MAX_MESSAGE_BYTES = MAX_MESSAGE_BYTES_DEF,
  localparam int CNT_W   = $clog2(MAX_MESSAGE_BYTES + 1),
  localparam int ENTRY_W = 2 + 32 + 32 + CNT_W + SUM_W + 8
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 q_not_empty,
  input  logic [ENTRY_W-1:0]   q_data,
  output logic                 q_pop,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [1:0]           out_status,
  output logic [31:0]          out_ip_source,
  output logic [31:0]          out_ip_destination,
  output logic [LEN_OUT_W-1:0] out_ip_total_length,
  output logic [LEN_OUT_W-1:0] out_udp_length,
  output logic [15:0]          out_ip_header_checksum,
  output logic [15:0]          out_udp_checksum
);

  localparam int LEN_W  = CNT_W + 2;
  localparam int ISUM_W = 20;

  // unpacked queue entry
  logic [1:0]       q_status;
  logic [31:0]      q_src;
  logic [31:0]      q_dst;
  logic [CNT_W-1:0] q_count;
  logic [SUM_W-1:0] q_sum;
  logic [7:0]       q_pad;

  logic advance;

  // stage a: address and message partial sums
  logic              a_v_r;
  status_t           a_status_r;
  logic [31:0]       a_src_r, a_dst_r;
  logic [LEN_W-1:0]  a_ulen_r, a_iplen_r;
  logic [HSUM_W-1:0] a_msg_r;
  logic [17:0]       a_addr_r;

  // stage b: full header sums
  logic              b_v_r;
  status_t           b_status_r;
  logic [31:0]       b_src_r, b_dst_r;
  logic [LEN_W-1:0]  b_ulen_r, b_iplen_r;
  logic [HSUM_W-1:0] b_usum_r;
  logic [ISUM_W-1:0] b_isum_r;

  // output register
  logic                 out_valid_r;
  logic [1:0]           status_r;
  logic [31:0]          src_r, dst_r;
  logic [LEN_OUT_W-1:0] iplen_r, ulen_r;
  logic [15:0]          ics_r, ucs_r;

  logic [15:0] ucs_fold;
  logic [15:0] ics_fold;
  logic [15:0] ucs_val;
  logic        b_ok;

  assign {q_status, q_src, q_dst, q_count, q_sum, q_pad} = q_data;

  // whole pipeline moves unless a held result is stalled
  assign advance = !out_valid_r || !out_stall;
  assign q_pop   = q_not_empty && advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r       <= 1'b0;
      b_v_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (advance) begin
      a_v_r       <= q_pop;
      b_v_r       <= a_v_r;
      out_valid_r <= b_v_r;
    end
  end

  // stage a payload
  always_ff @(posedge clk) begin
    if (q_pop) begin
      a_status_r <= status_t'(q_status);
      a_src_r    <= q_src;
      a_dst_r    <= q_dst;
      a_ulen_r   <= LEN_W'(q_count) + LEN_W'(UDP_HDR_BYTES);
      a_iplen_r  <= LEN_W'(q_count) + LEN_W'(UDP_HDR_BYTES + IP_HDR_BYTES);
      a_msg_r    <= HSUM_W'(q_sum) + HSUM_W'({q_pad, 8'h00});
      a_addr_r   <= 18'(q_src[31:16]) + 18'(q_src[15:0])
                  + 18'(q_dst[31:16]) + 18'(q_dst[15:0]);
    end
  end

  // stage b payload
  always_ff @(posedge clk) begin
    if (advance && a_v_r) begin
      b_status_r <= a_status_r;
      b_src_r    <= a_src_r;
      b_dst_r    <= a_dst_r;
      b_ulen_r   <= a_ulen_r;
      b_iplen_r  <= a_iplen_r;
      // pseudo-header, udp header with zero checksum field, message
      b_usum_r   <= HSUM_W'(a_addr_r) + a_msg_r
                  + HSUM_W'(PROTO_UDP + SERVER_PORT + CLIENT_PORT)
                  + HSUM_W'({a_ulen_r, 1'b0});
      b_isum_r   <= ISUM_W'(IP_VER_IHL + PROTO_UDP) + ISUM_W'(a_iplen_r)
                  + ISUM_W'(a_addr_r);
    end
  end

  // fold, complement, zero checksum substitution
  always_comb begin
    ucs_fold = ~fold16(b_usum_r);
    ics_fold = ~fold16(HSUM_W'(b_isum_r));
    ucs_val  = (ucs_fold == 16'h0000) ? 16'hffff : ucs_fold;
    b_ok     = (b_status_r == ST_OK);
  end

  // output register, error results carry zero fields
  always_ff @(posedge clk) begin
    if (advance && b_v_r) begin
      status_r <= b_status_r;
      src_r    <= b_ok ? b_src_r : '0;
      dst_r    <= b_ok ? b_dst_r : '0;
      iplen_r  <= b_ok ? LEN_OUT_W'(b_iplen_r) : '0;
      ulen_r   <= b_ok ? LEN_OUT_W'(b_ulen_r) : '0;
      ics_r    <= b_ok ? ics_fold : '0;
      ucs_r    <= b_ok ? ucs_val : '0;
    end
  end

  assign out_valid              = out_valid_r;
  assign out_status             = status_r;
  assign out_ip_source          = src_r;
  assign out_ip_destination     = dst_r;
  assign out_ip_total_length    = iplen_r;
  assign out_udp_length         = ulen_r;
  assign out_ip_header_checksum = ics_r;
  assign out_udp_checksum       = ucs_r;

endmodule

/* rtl/dhcp_reply_ipv4_udp_encapsulator_unit.sv */
`timescale 1ns / 1ps
// dhcp_reply_ipv4_udp_encapsulator_unit: top level with config register,
// front byte accumulator, summary queue and header back end; uses dhcpenc_pkg
//
//  channel | ports                                     | transfer when
//  --------+-------------------------------------------+------------------------------
//  in      | in_valid in_stall in_msg_byte in_last     | in_valid && !in_stall
//  out     | out_valid out_stall out_status out_ip_*.. | out_valid && !out_stall
//  config  | psel penable pwrite paddr pwdata prdata   | psel && penable && pwrite
//
// one message byte per cycle while in_stall is low; the front updates sum, count and
// field capture per accepted byte, and a result then passes the summary queue, stage
// a, stage b and the output register. reset (rst_n low, synchronous) clears message
// state, queue and pipeline and sets min_message_length to 236. in_stall rises only
// when the summary queue is full, which happens when out_stall holds back results.
module dhcp_reply_ipv4_udp_encapsulator_unit import dhcpenc_pkg::*; #(
  parameter int MAX_MESSAGE_BYTES = MAX_MESSAGE_BYTES_DEF,
  parameter int QUEUE_DEPTH       = QUEUE_DEPTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [7:0]            in_msg_byte,
  input  logic                  in_last,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [1:0]            out_status,
  output logic [31:0]           out_ip_source,
  output logic [31:0]           out_ip_destination,
  output logic [LEN_OUT_W-1:0]  out_ip_total_length,
  output logic [LEN_OUT_W-1:0]  out_udp_length,
  output logic [15:0]           out_ip_header_checksum,
  output logic [15:0]           out_udp_checksum,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  localparam int CNT_W   = $clog2(MAX_MESSAGE_BYTES + 1);
  localparam int ENTRY_W = 2 + 32 + 32 + CNT_W + SUM_W + 8;

  logic [MIN_LEN_W-1:0] min_len_r;
  logic                 reg_index;
  logic                 cfg_wr;

  logic               q_push, q_pop, q_full, q_not_empty;
  logic [ENTRY_W-1:0] q_wdata, q_rdata;

  // configuration register
  assign pready    = 1'b1;
  assign reg_index = paddr[2];
  assign cfg_wr    = psel && penable && pwrite && (reg_index == REG_MIN_LEN);
  assign prdata    = (reg_index == REG_MIN_LEN) ? APB_DATA_W'(min_len_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_len_r <= MIN_LEN_RESET;
    end else if (cfg_wr) begin
      min_len_r <= pwdata[MIN_LEN_W-1:0];
    end
  end

  dhcpenc_front #(
    .MAX_MESSAGE_BYTES(MAX_MESSAGE_BYTES)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_msg_byte(in_msg_byte),
    .in_last    (in_last),
    .min_len    (min_len_r),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_data     (q_wdata)
  );

  dhcpenc_fifo #(
    .WIDTH(ENTRY_W),
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_data(q_wdata),
    .pop      (q_pop),
    .pop_data (q_rdata),
    .full     (q_full),
    .not_empty(q_not_empty)
  );

  dhcpenc_back #(
    .MAX_MESSAGE_BYTES(MAX_MESSAGE_BYTES)
  ) u_back (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .q_not_empty           (q_not_empty),
    .q_data                (q_rdata),
    .q_pop                 (q_pop),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .out_status            (out_status),
    .out_ip_source         (out_ip_source),
    .out_ip_destination    (out_ip_destination),
    .out_ip_total_length   (out_ip_total_length),
    .out_udp_length        (out_udp_length),
    .out_ip_header_checksum(out_ip_header_checksum),
    .out_udp_checksum      (out_udp_checksum)
  );

endmodule

/* rtl/dhcpenc_checker.sv */
`timescale 1ns / 1ps
// dhcpenc_checker: port-level assertions for the encapsulator top level,
// bound to dhcp_reply_ipv4_udp_encapsulator_unit; uses dhcpenc_pkg
module dhcpenc_checker import dhcpenc_pkg::*; (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 out_valid,
  input logic                 out_stall,
  input logic [1:0]           out_status,
  input logic [31:0]          out_ip_source,
  input logic [LEN_OUT_W-1:0] out_ip_total_length,
  input logic [LEN_OUT_W-1:0] out_udp_length,
  input logic [15:0]          out_udp_checksum
);

  // no result comes out of reset
  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // a stalled result stays offered
  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  // a stalled result keeps its status, source, udp length and udp checksum
  a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_status) && $stable(out_udp_checksum)
      && $stable(out_ip_source) && $stable(out_udp_length))
    else $error("result changed while stalled");

  // error results carry zero source, udp length and udp checksum
  a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_OK |->
      out_ip_source == '0 && out_udp_length == '0 && out_udp_checksum == '0)
    else $error("error result with nonzero fields");

  // good results: lengths agree and the udp checksum is never sent as zero
  a_ok_lengths: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_OK |->
      out_ip_total_length == LEN_OUT_W'(out_udp_length + LEN_OUT_W'(IP_HDR_BYTES))
      && out_udp_checksum != 16'h0000)
    else $error("inconsistent header in good result");

endmodule

bind dhcp_reply_ipv4_udp_encapsulator_unit dhcpenc_checker u_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .out_valid          (out_valid),
  .out_stall          (out_stall),
  .out_status         (out_status),
  .out_ip_source      (out_ip_source),
  .out_ip_total_length(out_ip_total_length),
  .out_udp_length     (out_udp_length),
  .out_udp_checksum   (out_udp_checksum)
);

/* bench/tb_top.sv */
`timescale 1ns / 1ps
// tb_top: self-checking bench for dhcp_reply_ipv4_udp_encapsulator_unit, with a
// header predictor, byte driver, result monitor and apb register access;
// depends on dhcpenc_pkg and the unit rtl
module tb_top;
  import dhcpenc_pkg::*;

  localparam logic [APB_ADDR_W-1:0] MIN_LEN_ADDR = APB_ADDR_W'(4 * REG_MIN_LEN);
  localparam int MAX_BYTES = MAX_MESSAGE_BYTES_DEF;
  localparam int HOLD_CYCLES = 300;

  typedef logic [7:0] msg_bytes_t[$];

  typedef struct packed {
    logic [7:0] data;
    logic       is_last;
  } msg_item_t;

  typedef struct {
    status_t     status;
    logic [31:0] src;
    logic [31:0] dst;
    logic [10:0] total_len;
    logic [10:0] udp_len;
    logic [15:0] ip_csum;
    logic [15:0] udp_csum;
  } header_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [7:0]            in_msg_byte = '0;
  logic                  in_last = 1'b0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [1:0]            out_status;
  logic [31:0]           out_ip_source;
  logic [31:0]           out_ip_destination;
  logic [LEN_OUT_W-1:0]  out_ip_total_length;
  logic [LEN_OUT_W-1:0]  out_udp_length;
  logic [15:0]           out_ip_header_checksum;
  logic [15:0]           out_udp_checksum;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [APB_ADDR_W-1:0] paddr = '0;
  logic [APB_DATA_W-1:0] pwdata = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  // predictor state, mirrors the unit's message accumulator
  logic [26:0] msg_sum = '0;
  logic [10:0] msg_len = '0;
  logic [7:0]  odd_byte = '0;
  logic        bcast_bit = 1'b0;
  logic [31:0] your_addr = '0;
  logic [31:0] server_addr = '0;
  logic        len_overflow = 1'b0;
  logic [10:0] min_len_model = MIN_LEN_RESET;

  msg_item_t pending_bytes[$];
  header_t   expected_headers[$];

  int mismatch_count = 0;
  int send_gap_pct = 0;
  int stall_pct = 0;
  logic hold_start = 1'b0;
  int hold_left = 0;

  dhcp_reply_ipv4_udp_encapsulator_unit dut (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .in_valid               (in_valid),
    .in_stall               (in_stall),
    .in_msg_byte            (in_msg_byte),
    .in_last                (in_last),
    .out_valid              (out_valid),
    .out_stall              (out_stall),
    .out_status             (out_status),
    .out_ip_source          (out_ip_source),
    .out_ip_destination     (out_ip_destination),
    .out_ip_total_length    (out_ip_total_length),
    .out_udp_length         (out_udp_length),
    .out_ip_header_checksum (out_ip_header_checksum),
    .out_udp_checksum       (out_udp_checksum),
    .psel                   (psel),
    .penable                (penable),
    .pwrite                 (pwrite),
    .paddr                  (paddr),
    .pwdata                 (pwdata),
    .prdata                 (prdata),
    .pready                 (pready)
  );

  // clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // checksum arithmetic
  function automatic logic [31:0] addr_halves(input logic [31:0] a, input logic [31:0] b);
    return 32'(a[31:16]) + 32'(a[15:0]) + 32'(b[31:16]) + 32'(b[15:0]);
  endfunction

  function automatic logic [15:0] ones_fold(input logic [31:0] s);
    logic [31:0] t;
    t = 32'(s[15:0]) + 32'(s[31:16]);
    t = 32'(t[15:0]) + 32'(t[31:16]);
    return t[15:0];
  endfunction

  // pseudo-header plus udp header, checksum field zero, message not included
  function automatic logic [31:0] udp_sum_base(input logic [31:0] src, input logic [31:0] dst,
                                               input logic [31:0] ulen);
    return addr_halves(src, dst) + 32'(PROTO_UDP) + ulen
           + 32'(SERVER_PORT) + 32'(CLIENT_PORT) + ulen;
  endfunction

  task automatic log_mismatch(input string msg);
    $display("mismatch at %0t: %s", $time, msg);
    mismatch_count++;
  endtask

  task automatic compare_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
    if (got !== want) log_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
  endtask

  // fold one accepted byte into the predicted message state
  task automatic absorb_msg_byte(input logic [7:0] b, input logic is_last);
    header_t     h;
    logic [31:0] msum;
    logic [31:0] ulen;
    logic [31:0] iplen;
    logic [15:0] ucs;
    if (msg_len >= MAX_BYTES) begin
      len_overflow = 1'b1;
    end else begin
      if (msg_len == FLAG_BYTE) bcast_bit = b[7];
      else if (msg_len >= YIADDR_BYTE && msg_len < SIADDR_BYTE) your_addr = {your_addr[23:0], b};
      else if (msg_len >= SIADDR_BYTE && msg_len < ADDR_END) server_addr = {server_addr[23:0], b};
      if (!msg_len[0]) odd_byte = b;
      else msg_sum = msg_sum + 27'({odd_byte, b});
      msg_len = msg_len + 11'd1;
    end
    if (!is_last) return;

    h = '{status: ST_OK, default: '0};
    if (len_overflow) begin
      h.status = ST_TOO_LONG;
    end else if (msg_len < min_len_model) begin
      h.status = ST_TOO_SHORT;
    end else begin
      h.src = server_addr;
      h.dst = bcast_bit ? ADDR_ALL_ONES : your_addr;
      msum = 32'(msg_sum) + (msg_len[0] ? 32'({odd_byte, 8'h00}) : 32'd0);
      ulen = 32'(msg_len) + UDP_HDR_BYTES;
      iplen = ulen + IP_HDR_BYTES;
      ucs = ~ones_fold(udp_sum_base(h.src, h.dst, ulen) + msum);
      h.udp_csum = (ucs == 16'h0000) ? 16'hffff : ucs;
      h.ip_csum = ~ones_fold(32'(IP_VER_IHL) + iplen + 32'(PROTO_UDP) + addr_halves(h.src, h.dst));
      h.total_len = iplen[10:0];
      h.udp_len = ulen[10:0];
    end
    expected_headers.push_back(h);

    msg_sum = '0;
    msg_len = '0;
    odd_byte = '0;
    bcast_bit = 1'b0;
    your_addr = '0;
    server_addr = '0;
    len_overflow = 1'b0;
  endtask

  // byte driver, also tracks register writes for the predictor
  always @(posedge clk) begin
    msg_item_t item;
    if (psel && penable && pwrite && pready && paddr == MIN_LEN_ADDR)
      min_len_model = pwdata[10:0];
    if (rst_n && in_valid && !in_stall) absorb_msg_byte(in_msg_byte, in_last);
    if (!in_valid || !in_stall) begin
      if (rst_n && pending_bytes.size() != 0 && $urandom_range(0, 99) >= send_gap_pct) begin
        item = pending_bytes.pop_front();
        in_valid <= 1'b1;
        in_msg_byte <= item.data;
        in_last <= item.is_last;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result monitor and receiver stall
  always @(posedge clk) begin
    header_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_headers.size() == 0) begin
        log_mismatch("result transfer with nothing expected");
      end else begin
        e = expected_headers.pop_front();
        compare_field("status", 32'(out_status), 32'(e.status));
        compare_field("ip_source", out_ip_source, e.src);
        compare_field("ip_destination", out_ip_destination, e.dst);
        compare_field("ip_total_length", 32'(out_ip_total_length), 32'(e.total_len));
        compare_field("udp_length", 32'(out_udp_length), 32'(e.udp_len));
        compare_field("ip_header_checksum", 32'(out_ip_header_checksum), 32'(e.ip_csum));
        compare_field("udp_checksum", 32'(out_udp_checksum), 32'(e.udp_csum));
      end
    end
    out_stall <= rst_n && ((hold_left != 0) || ($urandom_range(0, 99) < stall_pct));
  end

  // long receiver hold-off counter
  always @(posedge clk) begin
    if (hold_start) begin
      hold_left <= HOLD_CYCLES;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  task automatic push_message(input msg_bytes_t bytes);
    foreach (bytes[k]) pending_bytes.push_back('{data: bytes[k], is_last: (k == bytes.size() - 1)});
  endtask

  task automatic queue_random_msg(input int len);
    msg_bytes_t bytes;
    for (int k = 0; k < len; k++) bytes.push_back(8'($urandom));
    push_message(bytes);
  endtask

  // wait until every byte is sent and every result is back, then let the pipe settle
  task automatic drain();
    do @(posedge clk);
    while (pending_bytes.size() != 0 || in_valid || expected_headers.size() != 0);
    repeat (12) @(posedge clk);
  endtask

  task automatic set_idling(input int send_pct, input int recv_pct);
    send_gap_pct <= send_pct;
    stall_pct <= recv_pct;
  endtask

  task automatic check_min_length();
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= MIN_LEN_ADDR;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk);
    while (!pready);
    if (prdata !== 32'(min_len_model))
      log_mismatch($sformatf("min_message_length read %0h expected %0h", prdata, min_len_model));
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_min_length(input logic [10:0] v);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= MIN_LEN_ADDR;
    pwdata <= {21'($urandom), v};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk);
    while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    check_min_length();
  endtask

  // stimulus sequence
  initial begin
    msg_bytes_t  msg;
    logic [31:0] src;
    logic [31:0] dst;
    logic [31:0] part;
    logic [15:0] fix;
    int          phase_min[4];
    int          pushed;
    int          len;

    phase_min = '{24, 4, 12, 30};
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    check_min_length();

    // reset threshold: exact minimum, one short, single byte
    queue_random_msg(236);
    queue_random_msg(235);
    queue_random_msg(1);
    drain();

    // smallest normal threshold, plus a message built to sum to a zero checksum
    set_min_length(11'd24);
    queue_random_msg(24);
    queue_random_msg(23);
    for (int k = 0; k < 24; k++) msg.push_back(8'($urandom));
    src = {msg[20], msg[21], msg[22], msg[23]};
    dst = msg[10][7] ? ADDR_ALL_ONES : {msg[16], msg[17], msg[18], msg[19]};
    part = udp_sum_base(src, dst, 32'(UDP_HDR_BYTES + 26));
    for (int k = 0; k < 24; k += 2) part = part + 32'({msg[k], msg[k + 1]});
    fix = ~ones_fold(part);
    msg.push_back(fix[15:8]);
    msg.push_back(fix[7:0]);
    push_message(msg);
    drain();

    // messages ending before the flag and address bytes are complete
    set_min_length(11'd1);
    queue_random_msg(1);
    queue_random_msg(11);
    queue_random_msg(18);
    drain();

    set_min_length(11'd0);
    queue_random_msg(2);
    drain();

    // random traffic under each idling pattern
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: set_idling(0, 0);
        1: set_idling(45, 0);
        2: set_idling(0, 45);
        default: set_idling(12, 12);
      endcase
      set_min_length(11'(phase_min[ph]));
      pushed = 0;
      while (pushed < 130) begin
        if ($urandom_range(0, 9) < 8) len = $urandom_range(phase_min[ph], phase_min[ph] + 25);
        else len = $urandom_range(1, phase_min[ph]);
        queue_random_msg(len);
        pushed += len;
      end
      drain();
    end

    // back-pressure: receiver holds off while short messages keep arriving
    set_idling(0, 0);
    set_min_length(11'd1);
    for (int k = 0; k < 60; k++) queue_random_msg($urandom_range(1, 4));
    hold_start <= 1'b1;
    @(posedge clk);
    hold_start <= 1'b0;
    drain();

    if (mismatch_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // run limit
  initial begin
    #1_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule

/* files.f */
rtl/dhcpenc_pkg.sv
rtl/dhcpenc_fifo.sv
rtl/dhcpenc_front.sv
rtl/dhcpenc_back.sv
rtl/dhcp_reply_ipv4_udp_encapsulator_unit.sv
rtl/dhcpenc_checker.sv
bench/tb_top.sv
